FILE: hw/rtl/assert_macros.svh
// assertion macros used by fm_voice_with_decay_envelope
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// condition holds in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/fmv_pkg.sv
// fm voice package: field widths, codes, reset values and sequencer states
// no dependencies
package fmv_pkg;

    localparam int INC_BITS        = 24;
    localparam int LEVEL_BITS      = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int OUT_SAMPLE_BITS = 16;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    localparam logic [CFG_DATA_BITS-1:0] RATIO_RESET = 16'd4096;
    localparam logic [CFG_DATA_BITS-1:0] INDEX_RESET = 16'd8192;
    localparam logic [CFG_DATA_BITS-1:0] FLOOR_RESET = 16'd3;

    typedef enum logic
    {
        CMD_TICK    = 1'b0,
        CMD_TRIGGER = 1'b1
    } cmd_t;

    typedef enum logic [CFG_INDEX_BITS-1:0]
    {
        CFG_RATIO = 2'd0,
        CFG_INDEX = 2'd1,
        CFG_FLOOR = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0]
    {
        ENT_PHASE = 2'd0,
        ENT_STEP  = 2'd1,
        ENT_LEVEL = 2'd2
    } entry_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_TRIG_STEP,
        ST_TRIG_PHASE,
        ST_TICK_LEVEL,
        ST_TICK_PHASE,
        ST_TICK_STEP,
        ST_TICK_CARRIER,
        ST_TICK_ENV,
        ST_TICK_SAMPLE,
        ST_EMIT
    } fsm_state_t;

endpackage

FILE: hw/rtl/fmv_in_if.sv
// input request channel of the fm voice
// depends on fmv_pkg
interface fmv_in_if import fmv_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [INC_BITS-1:0]   carrier_increment;
    logic [LEVEL_BITS-1:0] velocity;
    logic [LEVEL_BITS-1:0] decay_factor;

    modport source (output valid, command, carrier_increment, velocity, decay_factor,
                    input ready);
    modport sink (input valid, command, carrier_increment, velocity, decay_factor,
                  output ready);
endinterface

FILE: hw/rtl/fmv_out_if.sv
// sample output channel of the fm voice
// depends on fmv_pkg
interface fmv_out_if import fmv_pkg::*; ();
    logic                              valid;
    logic                              ready;
    logic signed [OUT_SAMPLE_BITS-1:0] sample;
    logic                              voice_active;

    modport source (output valid, sample, voice_active, input ready);
    modport sink (input valid, sample, voice_active, output ready);
endinterface

FILE: hw/rtl/fmv_cfg_if.sv
// register write channel of the fm voice
// depends on fmv_pkg
interface fmv_cfg_if import fmv_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/fmv_sine_rom.sv
// full-wave sine table with registered read, built at elaboration
// no dependencies
module fmv_sine_rom #(
    parameter int TABLE_BITS  = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic [TABLE_BITS-1:0]         addr,
    output logic signed [SAMPLE_BITS-1:0] q
);

    localparam int          TABLE_SIZE   = 1 << TABLE_BITS;
    localparam int          QUARTER_BITS = TABLE_BITS - 2;
    localparam int          QUARTER      = 1 << QUARTER_BITS;
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
    localparam logic [63:0] AMP          = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    typedef logic signed [SAMPLE_BITS-1:0] rom_t [TABLE_SIZE];

    // quarter wave by taylor series in q30
    function automatic logic [63:0] quarter_sine(input logic [63:0] k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] r;
        logic [63:0] v;
        x  = (k * HALF_PI_Q30) >> QUARTER_BITS;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        r  = (x * t) >> 30;
        v  = (r * AMP + (ONE_Q30 >> 1)) >> 30;
        if (v > AMP)
        begin
            v = AMP;
        end
        return v;
    endfunction

    function automatic rom_t build_rom();
        rom_t        rom;
        int          quad;
        logic [63:0] k;
        logic [63:0] s;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            quad = i >> QUARTER_BITS;
            k    = 64'(i & (QUARTER - 1));
            s    = quad[0] ? quarter_sine(64'(QUARTER) - k) : quarter_sine(k);
            rom[i] = quad[1] ? -(SAMPLE_BITS'(s)) : SAMPLE_BITS'(s);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic signed [SAMPLE_BITS-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        q_reg <= SINE_ROM[addr];
    end

    assign q = q_reg;

endmodule

FILE: hw/rtl/fmv_mul.sv
// shared signed multiplier with registered product
// no dependencies
module fmv_mul #(
    parameter int A_BITS = 25,
    parameter int B_BITS = 18
) (
    input  logic                            clk,
    input  logic signed [A_BITS-1:0]        a,
    input  logic signed [B_BITS-1:0]        b,
    output logic signed [A_BITS+B_BITS-1:0] p
);

    logic signed [A_BITS+B_BITS-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

FILE: hw/rtl/fm_voice_with_decay_envelope.sv
// top level of the two-operator fm voice: sequencer, state memory, registers
// depends on fmv_pkg, the channel interfaces, fmv_sine_rom, fmv_mul, assert_macros.svh
//
// A tick request on a sounding voice passes level, phase, step, carrier, env,
// sample and emit before the next request is accepted: its sample is loaded into
// the output register as the sequencer returns to idle, where the input is ready
// again. The sequence is set by the one-port state memory (three words read, two
// written back), the shared multiplier (four products) and the two sine table
// reads. A tick on a silent voice emits a zero sample marked inactive; a note
// trigger has no result. The input side keeps taking requests while a sample
// waits to be taken; only a finished sample that finds the output register full
// holds the sequencer. There is no clearing pass after reset: the state memory
// is read only while a note sounds, and every trigger writes all of it.
`include "assert_macros.svh"

module fm_voice_with_decay_envelope import fmv_pkg::*; #(
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    fmv_in_if.sink    voice_in,
    fmv_out_if.source voice_out,
    fmv_cfg_if.sink   cfg
);

    localparam int DW      = 2 * PHASE_BITS;
    localparam int AW      = ((PHASE_BITS > SAMPLE_BITS) ? PHASE_BITS : SAMPLE_BITS) + 1;
    localparam int BW      = 18;
    localparam int PW      = AW + BW;
    localparam int SFRAC   = SAMPLE_BITS - 1;
    localparam int OFF_SH  = SAMPLE_BITS + 11 - PHASE_BITS;
    localparam int OFF_R   = (OFF_SH > 0) ? OFF_SH : 0;
    localparam int OFF_L   = (OFF_SH < 0) ? -OFF_SH : 0;
    localparam int STEP_UP = (PHASE_BITS > INC_BITS) ? PHASE_BITS - INC_BITS : 0;
    localparam int STEP_DN = (PHASE_BITS < INC_BITS) ? INC_BITS - PHASE_BITS : 0;
    localparam int ENTRIES = 3;

    fsm_state_t state_reg, state_next;

    logic [CFG_DATA_BITS-1:0] ratio_reg;
    logic [CFG_DATA_BITS-1:0] mod_index_reg;
    logic [CFG_DATA_BITS-1:0] floor_reg;
    logic                     active_reg;
    logic                     out_valid_reg;

    logic [PHASE_BITS-1:0]             cstep_reg;
    logic [PHASE_BITS-1:0]             cp_reg;
    logic [PHASE_BITS-1:0]             mp_reg;
    logic [LEVEL_BITS-1:0]             env_reg;
    logic [LEVEL_BITS-1:0]             decay_reg;
    logic signed [BW-1:0]              depth_reg;
    logic signed [OUT_SAMPLE_BITS-1:0] smp_reg;
    logic                              alive_reg;
    logic signed [OUT_SAMPLE_BITS-1:0] out_sample_reg;
    logic                              out_active_reg;

    logic [DW-1:0] state_mem [ENTRIES];
    logic [DW-1:0] ram_rdata_reg;
    logic          ram_we;
    logic          ram_re;
    entry_t        ram_waddr;
    entry_t        ram_raddr;
    logic [DW-1:0] ram_wdata;

    logic                   in_ready;
    logic                   in_accept;
    logic                   is_trigger;
    logic                   out_free;
    logic [PHASE_BITS-1:0]  cstep_in;
    logic [PHASE_BITS-1:0]  rd_hi;
    logic [PHASE_BITS-1:0]  rd_lo;
    logic [LEVEL_BITS-1:0]  rd_env;
    logic [LEVEL_BITS-1:0]  rd_decay;

    logic signed [AW-1:0]          mul_a;
    logic signed [BW-1:0]          mul_b;
    logic signed [PW-1:0]          mul_p;
    logic [SINE_TABLE_BITS-1:0]    rom_addr;
    logic signed [SAMPLE_BITS-1:0] rom_q;

    logic signed [PW-1:0]              off_wide;
    logic [PHASE_BITS-1:0]             cmod;
    logic [LEVEL_BITS-1:0]             env_new;
    logic                              env_cut;
    logic [LEVEL_BITS-1:0]             env_kept;
    logic signed [PW-1:0]              smp_wide;
    logic signed [OUT_SAMPLE_BITS-1:0] smp_sat;

    fmv_sine_rom #(
        .TABLE_BITS  (SINE_TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .q    (rom_q)
    );

    fmv_mul #(
        .A_BITS (AW),
        .B_BITS (BW)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign in_accept  = voice_in.valid && in_ready;
    assign is_trigger = (voice_in.command == CMD_TRIGGER);
    assign out_free   = !out_valid_reg || voice_out.ready;
    assign cstep_in   = PHASE_BITS'((64'(voice_in.carrier_increment) << STEP_UP) >> STEP_DN);

    assign rd_hi    = ram_rdata_reg[DW-1:PHASE_BITS];
    assign rd_lo    = ram_rdata_reg[PHASE_BITS-1:0];
    assign rd_env   = ram_rdata_reg[31:16];
    assign rd_decay = ram_rdata_reg[15:0];

    // datapath around the multiplier output
    assign off_wide = (mul_p >>> OFF_R) <<< OFF_L;
    assign cmod     = cp_reg + off_wide[PHASE_BITS-1:0];
    assign env_new  = mul_p[31:16];
    assign env_cut  = (env_new < floor_reg);
    assign env_kept = env_cut ? '0 : env_new;
    assign smp_wide = mul_p >>> SFRAC;

    always_comb
    begin
        priority if (smp_wide > PW'(SAMPLE_MAX))
        begin
            smp_sat = OUT_SAMPLE_BITS'(SAMPLE_MAX);
        end
        else if (smp_wide < PW'(SAMPLE_MIN))
        begin
            smp_sat = OUT_SAMPLE_BITS'(SAMPLE_MIN);
        end
        else
        begin
            smp_sat = smp_wide[OUT_SAMPLE_BITS-1:0];
        end
    end

    assign rom_addr = (state_reg == ST_TICK_PHASE) ? rd_lo[PHASE_BITS-1 -: SINE_TABLE_BITS]
                                                   : cmod[PHASE_BITS-1 -: SINE_TABLE_BITS];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (is_trigger)
                    begin
                        state_next = ST_TRIG_STEP;
                    end
                    else if (active_reg)
                    begin
                        state_next = ST_TICK_LEVEL;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_TRIG_STEP:    state_next = ST_TRIG_PHASE;
            ST_TRIG_PHASE:   state_next = ST_IDLE;
            ST_TICK_LEVEL:   state_next = ST_TICK_PHASE;
            ST_TICK_PHASE:   state_next = ST_TICK_STEP;
            ST_TICK_STEP:    state_next = ST_TICK_CARRIER;
            ST_TICK_CARRIER: state_next = ST_TICK_ENV;
            ST_TICK_ENV:     state_next = ST_TICK_SAMPLE;
            ST_TICK_SAMPLE:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:         state_next = ST_IDLE;
        endcase
    end

    // memory, multiplier and handshake controls
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = ENT_PHASE;
        ram_raddr = ENT_LEVEL;
        ram_wdata = '0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                mul_a    = AW'(cstep_in);
                mul_b    = BW'(ratio_reg);
                if (in_accept && is_trigger)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ENT_LEVEL;
                    ram_wdata = DW'({voice_in.velocity, voice_in.decay_factor});
                end
                else if (in_accept && active_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ENT_LEVEL;
                end
            end
            ST_TRIG_STEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = ENT_STEP;
                ram_wdata = {cstep_reg, mul_p[12 +: PHASE_BITS]};
            end
            ST_TRIG_PHASE:
            begin
                ram_we    = 1'b1;
                ram_waddr = ENT_PHASE;
                ram_wdata = '0;
            end
            ST_TICK_LEVEL:
            begin
                ram_re    = 1'b1;
                ram_raddr = ENT_PHASE;
                mul_a     = AW'(mod_index_reg);
                mul_b     = BW'(rd_env);
            end
            ST_TICK_PHASE:
            begin
                ram_re    = 1'b1;
                ram_raddr = ENT_STEP;
            end
            ST_TICK_STEP:
            begin
                mul_a     = AW'(rom_q);
                mul_b     = depth_reg;
                ram_we    = 1'b1;
                ram_waddr = ENT_PHASE;
                ram_wdata = {PHASE_BITS'(cp_reg + rd_hi), PHASE_BITS'(mp_reg + rd_lo)};
            end
            ST_TICK_CARRIER:
            begin
                mul_a = AW'(env_reg);
                mul_b = BW'(decay_reg);
            end
            ST_TICK_ENV:
            begin
                mul_a     = AW'(rom_q);
                mul_b     = BW'(env_reg);
                ram_we    = 1'b1;
                ram_waddr = ENT_LEVEL;
                ram_wdata = DW'({env_kept, decay_reg});
            end
            ST_TICK_SAMPLE:
            begin
            end
            ST_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            state_mem[ram_waddr] <= ram_wdata;
        end
        if (ram_re)
        begin
            ram_rdata_reg <= state_mem[ram_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ratio_reg     <= RATIO_RESET;
            mod_index_reg <= INDEX_RESET;
            floor_reg     <= FLOOR_RESET;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    CFG_RATIO: ratio_reg     <= cfg.data;
                    CFG_INDEX: mod_index_reg <= cfg.data;
                    CFG_FLOOR: floor_reg     <= cfg.data;
                    default:   ;
                endcase
            end
            if (state_reg == ST_TRIG_PHASE)
            begin
                active_reg <= 1'b1;
            end
            else if (state_reg == ST_TICK_ENV)
            begin
                active_reg <= !env_cut;
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (voice_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && is_trigger)
                begin
                    cstep_reg <= cstep_in;
                end
                else if (in_accept)
                begin
                    smp_reg   <= '0;
                    alive_reg <= 1'b0;
                end
            end
            ST_TICK_LEVEL:
            begin
                env_reg   <= rd_env;
                decay_reg <= rd_decay;
            end
            ST_TICK_PHASE:
            begin
                cp_reg    <= rd_hi;
                mp_reg    <= rd_lo;
                depth_reg <= {1'b0, mul_p[31:15]};
            end
            ST_TICK_ENV:
            begin
                alive_reg <= !env_cut;
            end
            ST_TICK_SAMPLE:
            begin
                smp_reg <= smp_sat;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_sample_reg <= smp_reg;
                    out_active_reg <= alive_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign voice_in.ready         = in_ready;
    assign cfg.ready              = 1'b1;
    assign voice_out.valid        = out_valid_reg;
    assign voice_out.sample       = out_sample_reg;
    assign voice_out.voice_active = out_active_reg;

    `ASSERT_ALWAYS(a_no_rw_same_entry, clk, rst_n, !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_accept, state_reg != ST_IDLE)
    `ASSERT_NEXT(a_trigger_sets_active, clk, rst_n, state_reg == ST_TRIG_PHASE, active_reg)
    `ASSERT_NEXT(a_emit_loads_out, clk, rst_n, (state_reg == ST_EMIT) && out_free, out_valid_reg && (state_reg == ST_IDLE))

endmodule
